// ----- hdl/pbsg_pkg.sv -----
// Shared types, codes and constants of the purpose-bound session gate.
// No dependencies; all other files of the gate import this package.
package pbsg_pkg;

    localparam logic [31:0] MAX_WINDOW_MS   = 32'd600000;
    localparam logic [7:0]  QUERY_USES_CAP  = 8'd16;
    localparam logic [2:0]  PURPOSE_INSERT  = 3'd1;
    localparam logic [2:0]  PURPOSE_QUERY   = 3'd4;
    localparam logic [31:0] RST_WINDOW_MS   = 32'd60000;
    localparam logic [7:0]  RST_QUERY_LIMIT = 8'd4;

    localparam int NUM_CNT       = 9;
    localparam int CNT_STATE     = 0;
    localparam int CNT_PURPOSE   = 1;
    localparam int CNT_FORMAT    = 2;
    localparam int CNT_TIME      = 3;
    localparam int CNT_ASSERT    = 4;
    localparam int CNT_EXPIRED   = 5;
    localparam int CNT_BEGUN     = 6;
    localparam int CNT_CONSUMED  = 7;
    localparam int CNT_CANCELLED = 8;

    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_LIMIT  = 1'b1;

    typedef enum logic [2:0] {
        CMD_BEGIN    = 3'd0,
        CMD_VALIDATE = 3'd1,
        CMD_CONSUME  = 3'd2,
        CMD_CANCEL   = 3'd3,
        CMD_REINIT   = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_STATE   = 3'd1,
        ST_PURPOSE = 3'd2,
        ST_FORMAT  = 3'd3,
        ST_TIME    = 3'd4,
        ST_ASSERT  = 3'd5,
        ST_CONFIG  = 3'd6
    } status_t;

    typedef enum logic [5:0] {
        MODE_IDLE      = 6'b000001,
        MODE_ACTIVE    = 6'b000010,
        MODE_BLOCKED   = 6'b000100,
        MODE_EXPIRED   = 6'b001000,
        MODE_CONSUMED  = 6'b010000,
        MODE_CANCELLED = 6'b100000
    } mode_t;

    localparam logic [2:0] GS_IDLE      = 3'd0;
    localparam logic [2:0] GS_ACTIVE    = 3'd1;
    localparam logic [2:0] GS_BLOCKED   = 3'd2;
    localparam logic [2:0] GS_EXPIRED   = 3'd3;
    localparam logic [2:0] GS_CONSUMED  = 3'd4;
    localparam logic [2:0] GS_CANCELLED = 3'd5;

    typedef struct packed {
        logic [2:0]  command;
        logic [2:0]  purpose;
        logic [31:0] session_id;
        logic [31:0] evt_nonce;
        logic [7:0]  event_confirmed;
        logic [7:0]  uses_wanted;
        logic [31:0] time_now_ms;
    } item_t;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] floor_id;
        logic [31:0] active_id;
        logic [2:0]  purpose;
        logic [31:0] start_time;
        logic [31:0] expiry_time;
        logic [7:0]  uses;
        logic [31:0] lat_window;
        logic [7:0]  lat_limit;
    } sess_t;

    typedef struct packed {
        logic               clear;
        logic [NUM_CNT-1:0] inc;
    } cnt_ctl_t;

    typedef logic [NUM_CNT-1:0][31:0] cnt_arr_t;

    localparam sess_t SESS_RESET = '{
        mode:        MODE_IDLE,
        floor_id:    32'd0,
        active_id:   32'd0,
        purpose:     3'd0,
        start_time:  32'd0,
        expiry_time: 32'd0,
        uses:        8'd0,
        lat_window:  RST_WINDOW_MS,
        lat_limit:   RST_QUERY_LIMIT
    };

    function automatic logic [2:0] mode_code(mode_t m);
        logic [2:0] code;
        unique case (m)
            MODE_IDLE:      code = GS_IDLE;
            MODE_ACTIVE:    code = GS_ACTIVE;
            MODE_BLOCKED:   code = GS_BLOCKED;
            MODE_EXPIRED:   code = GS_EXPIRED;
            MODE_CONSUMED:  code = GS_CONSUMED;
            MODE_CANCELLED: code = GS_CANCELLED;
            default:        code = GS_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ----- hdl/pbsg_decide.sv -----
// Command evaluation of the gate: checks in order, next session state,
// status and counter controls. Combinational; depends on pbsg_pkg.
module pbsg_decide (
    input  pbsg_pkg::sess_t    cur,
    input  pbsg_pkg::item_t    item,
    input  logic [31:0]        cfg_window,
    input  logic [7:0]         cfg_limit,
    output pbsg_pkg::sess_t    nxt,
    output pbsg_pkg::status_t  status,
    output pbsg_pkg::cnt_ctl_t ctl
);
    import pbsg_pkg::*;

    function automatic sess_t clear_sess(sess_t s, mode_t m);
        sess_t r;
        r             = s;
        r.active_id   = '0;
        r.purpose     = '0;
        r.start_time  = '0;
        r.expiry_time = '0;
        r.uses        = '0;
        r.mode        = m;
        return r;
    endfunction

    logic p_ok;
    logic req_bad;
    logic cfg_bad;

    assign p_ok    = (item.purpose >= PURPOSE_INSERT) && (item.purpose <= PURPOSE_QUERY);
    assign req_bad = (item.purpose == PURPOSE_QUERY)
                   ? ((item.uses_wanted == 8'd0) || (item.uses_wanted > cur.lat_limit))
                   : (item.uses_wanted != 8'd1);
    assign cfg_bad = (cfg_window == 32'd0) || (cfg_window > MAX_WINDOW_MS) ||
                     (cfg_limit == 8'd0) || (cfg_limit > QUERY_USES_CAP);

    always_comb begin
        nxt    = cur;
        status = ST_OK;
        ctl    = '0;
        unique case (cmd_t'(item.command))
            CMD_BEGIN: begin
                if (cur.mode == MODE_BLOCKED || cur.mode == MODE_ACTIVE) begin
                    status = ST_STATE;
                    ctl.inc[CNT_STATE] = 1'b1;
                end else if (!p_ok) begin
                    status = ST_PURPOSE;
                    ctl.inc[CNT_PURPOSE] = 1'b1;
                end else if (item.session_id == 32'd0 || item.evt_nonce == 32'd0 ||
                             item.event_confirmed != 8'd1 ||
                             item.session_id <= cur.floor_id) begin
                    status = ST_FORMAT;
                    ctl.inc[CNT_FORMAT] = 1'b1;
                end else if (item.time_now_ms > ~cur.lat_window) begin
                    status = ST_TIME;
                    ctl.inc[CNT_TIME] = 1'b1;
                end else if (req_bad) begin
                    status = ST_ASSERT;
                    ctl.inc[CNT_ASSERT] = 1'b1;
                end else begin
                    nxt.floor_id    = item.session_id;
                    nxt.active_id   = item.session_id;
                    nxt.purpose     = item.purpose;
                    nxt.start_time  = item.time_now_ms;
                    nxt.expiry_time = item.time_now_ms + cur.lat_window;
                    nxt.uses        = item.uses_wanted;
                    nxt.mode        = MODE_ACTIVE;
                    ctl.inc[CNT_BEGUN] = 1'b1;
                end
            end
            CMD_VALIDATE, CMD_CONSUME: begin
                if (!p_ok) begin
                    status = ST_PURPOSE;
                    ctl.inc[CNT_PURPOSE] = 1'b1;
                end else if (cur.mode != MODE_ACTIVE) begin
                    status = ST_STATE;
                    ctl.inc[CNT_STATE] = 1'b1;
                end else if (item.time_now_ms < cur.start_time) begin
                    status = ST_TIME;
                    ctl.inc[CNT_TIME] = 1'b1;
                end else if (item.time_now_ms > cur.expiry_time) begin
                    status = ST_TIME;
                    ctl.inc[CNT_EXPIRED] = 1'b1;
                    nxt = clear_sess(cur, MODE_EXPIRED);
                end else if (item.purpose != cur.purpose) begin
                    status = ST_PURPOSE;
                    ctl.inc[CNT_PURPOSE] = 1'b1;
                end else if (item.session_id == 32'd0 ||
                             item.session_id != cur.active_id) begin
                    status = ST_ASSERT;
                    ctl.inc[CNT_ASSERT] = 1'b1;
                end else if (cur.uses == 8'd0) begin
                    status = ST_STATE;
                    ctl.inc[CNT_STATE] = 1'b1;
                    nxt = clear_sess(cur, MODE_BLOCKED);
                end else if (item.command == CMD_CONSUME) begin
                    ctl.inc[CNT_CONSUMED] = 1'b1;
                    if (cur.uses == 8'd1) begin
                        nxt = clear_sess(cur, MODE_CONSUMED);
                    end else begin
                        nxt.uses = cur.uses - 8'd1;
                    end
                end
            end
            CMD_CANCEL: begin
                if (cur.mode != MODE_ACTIVE) begin
                    status = ST_STATE;
                    ctl.inc[CNT_STATE] = 1'b1;
                end else begin
                    ctl.inc[CNT_CANCELLED] = 1'b1;
                    nxt = clear_sess(cur, MODE_CANCELLED);
                end
            end
            CMD_REINIT: begin
                ctl.clear    = 1'b1;
                nxt          = clear_sess(cur, MODE_IDLE);
                nxt.floor_id = '0;
                if (cfg_bad) begin
                    nxt.lat_window = '0;
                    nxt.lat_limit  = '0;
                    nxt.mode       = MODE_BLOCKED;
                    status         = ST_CONFIG;
                end else begin
                    nxt.lat_window = cfg_window;
                    nxt.lat_limit  = cfg_limit;
                end
            end
            default: begin
                status = ST_STATE;
            end
        endcase
    end

endmodule

// ----- hdl/pbsg_counters.sv -----
// Nine wrapping 32-bit event counters with a common clear.
// Depends on pbsg_pkg for the control struct and counter array type.
module pbsg_counters (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  pbsg_pkg::cnt_ctl_t ctl,
    output pbsg_pkg::cnt_arr_t cnt
);
    import pbsg_pkg::*;

    cnt_arr_t cnt_reg;
    cnt_arr_t cnt_next;

    always_comb begin
        for (int i = 0; i < NUM_CNT; i++) begin
            if (ctl.clear) begin
                cnt_next[i] = '0;
            end else begin
                cnt_next[i] = cnt_reg[i] + {31'd0, ctl.inc[i]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (en) begin
            cnt_reg <= cnt_next;
        end
    end

    assign cnt = cnt_reg;

endmodule

// ----- hdl/purpose_bound_session_gate.sv -----
// Top level of the purpose-bound session gate: input register, session
// state, result register and configuration port. Uses pbsg_pkg, pbsg_decide, pbsg_counters.
//
// One command is taken per clock cycle while m_ready does not hold back a
// result. An accepted command sits in the input register until the result
// register is free, is evaluated against the session state by a single layer
// of compares and one 32-bit add, and its result is registered on the m_ side.
// The session state, the nine counters and the result are all updated at the
// same edge, so gate_state, uses_left and the counters shown with each result
// are the values after that command. The configuration registers take effect
// only at the next reinit command; after reset the gate runs with a 60000 ms
// window and a query limit of 4. There is no clearing pass after reset.
module purpose_bound_session_gate (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [2:0]  s_purpose,
    input  logic [31:0] s_session_id,
    input  logic [31:0] s_evt_nonce,
    input  logic [7:0]  s_event_confirmed,
    input  logic [7:0]  s_uses_wanted,
    input  logic [31:0] s_time_now_ms,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [2:0]  m_gate_state,
    output logic [7:0]  m_uses_left,
    output logic [31:0] m_count_rejected_state,
    output logic [31:0] m_count_rejected_purpose,
    output logic [31:0] m_count_rejected_format,
    output logic [31:0] m_count_rejected_time,
    output logic [31:0] m_count_rejected_assertion,
    output logic [31:0] m_count_expired,
    output logic [31:0] m_count_begun,
    output logic [31:0] m_count_consumed,
    output logic [31:0] m_count_cancelled,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import pbsg_pkg::*;

    logic        in_valid_reg;
    item_t       item_reg;
    logic        out_valid_reg;
    status_t     status_reg;
    sess_t       sess_reg;
    sess_t       sess_next;
    status_t     status_next;
    cnt_ctl_t    cnt_ctl;
    cnt_arr_t    cnt;
    logic [31:0] cfg_window_reg;
    logic [7:0]  cfg_limit_reg;
    logic        advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // hold the command until the result slot is free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= '{command:         s_command,
                          purpose:         s_purpose,
                          session_id:      s_session_id,
                          evt_nonce:       s_evt_nonce,
                          event_confirmed: s_event_confirmed,
                          uses_wanted:     s_uses_wanted,
                          time_now_ms:     s_time_now_ms};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_window_reg <= RST_WINDOW_MS;
            cfg_limit_reg  <= RST_QUERY_LIMIT;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_WINDOW) begin
                cfg_window_reg <= cfg_data;
            end else begin
                cfg_limit_reg <= cfg_data[7:0];
            end
        end
    end

    pbsg_decide u_decide (
        .cur        (sess_reg),
        .item       (item_reg),
        .cfg_window (cfg_window_reg),
        .cfg_limit  (cfg_limit_reg),
        .nxt        (sess_next),
        .status     (status_next),
        .ctl        (cnt_ctl)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sess_reg <= SESS_RESET;
        end else if (advance) begin
            sess_reg <= sess_next;
        end
    end

    pbsg_counters u_counters (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .ctl     (cnt_ctl),
        .cnt     (cnt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            status_reg <= status_next;
        end
    end

    assign m_valid                    = out_valid_reg;
    assign m_status                   = status_reg;
    assign m_gate_state               = mode_code(sess_reg.mode);
    assign m_uses_left                = sess_reg.uses;
    assign m_count_rejected_state     = cnt[CNT_STATE];
    assign m_count_rejected_purpose   = cnt[CNT_PURPOSE];
    assign m_count_rejected_format    = cnt[CNT_FORMAT];
    assign m_count_rejected_time      = cnt[CNT_TIME];
    assign m_count_rejected_assertion = cnt[CNT_ASSERT];
    assign m_count_expired            = cnt[CNT_EXPIRED];
    assign m_count_begun              = cnt[CNT_BEGUN];
    assign m_count_consumed           = cnt[CNT_CONSUMED];
    assign m_count_cancelled          = cnt[CNT_CANCELLED];

    a_uses_match_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (sess_reg.mode == MODE_ACTIVE) == (sess_reg.uses != 8'd0))
        else $error("uses_left disagrees with active session");

    a_reinit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item_reg.command == CMD_REINIT) |=>
            (m_count_begun == 32'd0 && m_count_expired == 32'd0 &&
             m_count_rejected_state == 32'd0 && m_uses_left == 8'd0))
        else $error("reinit left counters or session state");

    a_hold_while_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            ($stable(sess_reg) && $stable(m_count_begun) && $stable(m_count_consumed)))
        else $error("state changed while a result transfer was pending");

endmodule
